// ===== hdl/lpht_pkg.sv =====
// Shared types and codes for the linear-probing hash table.
// Depends on nothing; every other file of the block but lpht_fifo imports it.
`default_nettype none

package lpht_pkg;

	// Key and value widths.
	localparam int KEY_W   = 32;
	localparam int DATA_W  = 32;

	// Command codes.
	localparam logic [1:0] CMD_INSERT = 2'd0;
	localparam logic [1:0] CMD_LOOKUP = 2'd1;
	localparam logic [1:0] CMD_REMOVE = 2'd2;

	// Result status codes.
	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_NOT_FOUND = 2'd1;
	localparam logic [1:0] ST_FULL      = 2'd2;

	// Per-slot state codes.
	localparam logic [1:0] SLOT_EMPTY    = 2'd0;
	localparam logic [1:0] SLOT_OCCUPIED = 2'd1;
	localparam logic [1:0] SLOT_DELETED  = 2'd2;

	// One command as it enters the block.
	typedef struct packed {
		logic [1:0]               command;
		logic [KEY_W-1:0]         key;
		logic signed [DATA_W-1:0] item_value;
	} cmd_in_t;

	// One result as it leaves the block.
	typedef struct packed {
		logic [1:0]               status;
		logic signed [DATA_W-1:0] found_value;
	} result_t;

	// One table slot as it is held in the slot memory.
	typedef struct packed {
		logic [1:0]               state;
		logic [KEY_W-1:0]         key;
		logic signed [DATA_W-1:0] data;
	} slot_t;

endpackage

`default_nettype wire

// ===== hdl/linear_probe_hash_table_top.sv =====
// Top level of the linear-probing hash table: front end, command queue and probe sequencer.
// Depends on lpht_pkg, lpht_front, lpht_fifo and lpht_back.
`default_nettype none

// Open-addressing key/value table of TABLE_SIZE slots with linear probing and
// deleted tombstones. Commands enter through a queue-style port (push/full) and
// results leave through another (empty/pop), one result per command, in order.
// After reset the slot memory is cleared one slot per cycle, and full stays high
// until the clearing pass is done. The front end computes the home slot by
// multiplying with a reciprocal of the table size, in a quotient step and then a
// remainder step, and takes no new command until the previous one has moved into
// the queue; this overlaps with probing of the previous command. The probe
// sequencer reads one slot per cycle from the slot memory, and a command
// examines at most TABLE_SIZE slots; the result register lets it start the next
// command while a result waits to be popped.
module linear_probe_hash_table_top #(
	parameter int TABLE_SIZE = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	output logic              full,
	input  lpht_pkg::cmd_in_t cmd_in,
	output logic              empty,
	input  logic              pop,
	output lpht_pkg::result_t result
);
	import lpht_pkg::*;

	localparam int AW = $clog2(TABLE_SIZE);
	localparam int EW = $bits(cmd_in_t) + AW;

	logic          clearing;
	logic          front_push;
	logic          front_full;
	logic          q_push;
	logic          q_full;
	cmd_in_t       q_item;
	logic [AW-1:0] q_home;
	logic          q_empty;
	logic          q_pop;
	logic [EW-1:0] q_rdata;
	cmd_in_t       entry_item;
	logic [AW-1:0] entry_home;

	// No transfer is taken while the slot memory is being cleared.
	assign front_push = push && !clearing;
	assign full       = front_full || clearing;

	assign entry_item = q_rdata[EW-1:AW];
	assign entry_home = q_rdata[AW-1:0];

	lpht_front #(
		.TABLE_SIZE(TABLE_SIZE)
	) u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (front_push),
		.full   (front_full),
		.cmd_in (cmd_in),
		.q_push (q_push),
		.q_full (q_full),
		.q_item (q_item),
		.q_home (q_home)
	);

	lpht_fifo #(
		.WIDTH(EW)
	) u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.full   (q_full),
		.wdata  ({q_item, q_home}),
		.pop    (q_pop),
		.empty  (q_empty),
		.rdata  (q_rdata)
	);

	lpht_back #(
		.TABLE_SIZE(TABLE_SIZE)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.entry_valid (!q_empty),
		.entry_pop   (q_pop),
		.entry_item  (entry_item),
		.entry_home  (entry_home),
		.clearing    (clearing),
		.empty       (empty),
		.pop         (pop),
		.result      (result)
	);

endmodule

`default_nettype wire

// ===== hdl/lpht_front.sv =====
// Front end: accepts commands and computes the home slot (key modulo table size).
// Depends on lpht_pkg; feeds the command queue in front of lpht_back.
`default_nettype none

module lpht_front #(
	parameter int TABLE_SIZE = 16,
	localparam int AW = $clog2(TABLE_SIZE)
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	output logic              full,
	input  lpht_pkg::cmd_in_t cmd_in,
	output logic              q_push,
	input  logic              q_full,
	output lpht_pkg::cmd_in_t q_item,
	output logic [AW-1:0]     q_home
);
	import lpht_pkg::*;

	// Reciprocal of the table size, exact for every key of KEY_W bits.
	localparam int RW = KEY_W + 1;
	localparam logic [63:0] RECIP_FULL =
		((64'd1 << (KEY_W + AW)) + 64'(TABLE_SIZE - 1)) / 64'(TABLE_SIZE);
	localparam logic [RW-1:0] RECIP = RECIP_FULL[RW-1:0];
	localparam logic [AW-1:0] MOD_LOW = AW'(TABLE_SIZE);
	localparam logic LAST_STEP = 1'b1;

	logic                  busy_q;
	logic                  have_q;
	logic                  step_q;
	logic [AW-1:0]         quo_q;
	logic [AW-1:0]         rem_q;
	cmd_in_t               item_q;
	logic                  accept;
	logic                  release_item;
	logic                  compute;
	logic [KEY_W+RW-1:0]   product;
	logic [AW-1:0]         quo_next;
	logic [AW-1:0]         back_mul;
	logic [AW-1:0]         rem_next;

	// A new command is taken once the previous one has moved into the queue.
	assign full         = busy_q && !(have_q && !q_full);
	assign accept       = push && !full;
	assign release_item = have_q && !q_full;
	assign compute      = busy_q && !have_q;

	assign q_push = have_q;
	assign q_item = item_q;
	assign q_home = rem_q;

	// First step: the low bits of the quotient from the reciprocal product.
	assign product  = item_q.key * RECIP;
	assign quo_next = product[KEY_W+AW +: AW];

	// Second step: the remainder fits in AW bits, so only the low bits are formed.
	assign back_mul = quo_q * MOD_LOW;
	assign rem_next = item_q.key[AW-1:0] - back_mul;

	// Control flags and the step counter.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			have_q <= 1'b0;
			step_q <= 1'b0;
		end else if (accept) begin
			busy_q <= 1'b1;
			have_q <= 1'b0;
			step_q <= 1'b0;
		end else if (release_item) begin
			busy_q <= 1'b0;
			have_q <= 1'b0;
		end else if (compute) begin
			step_q <= step_q + 1'b1;
			if (step_q == LAST_STEP) begin
				have_q <= 1'b1;
			end
		end
	end

	// Command payload, quotient and remainder.
	always_ff @(posedge clk) begin
		if (accept) begin
			item_q <= cmd_in;
		end else if (compute) begin
			if (step_q == LAST_STEP) begin
				rem_q <= rem_next;
			end else begin
				quo_q <= quo_next;
			end
		end
	end

`ifndef ASSERT_OFF
	a_have_implies_busy: assert property (@(posedge clk) disable iff (!arst_n)
		have_q |-> busy_q)
		else $error("front holds a home slot without a command in flight");
	a_last_step_done: assert property (@(posedge clk) disable iff (!arst_n)
		(compute && step_q == LAST_STEP) |=> have_q)
		else $error("front did not finish after the last remainder step");
	a_idle_not_full: assert property (@(posedge clk) disable iff (!arst_n)
		!busy_q |-> !full)
		else $error("idle front refuses a transfer");
`endif

endmodule

`default_nettype wire

// ===== hdl/lpht_fifo.sv =====
// Two-entry queue that decouples the front end from the probe sequencer.
// Depends on nothing beyond its WIDTH parameter.
`default_nettype none

module lpht_fifo #(
	parameter int WIDTH = 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	output logic             full,
	input  logic [WIDTH-1:0] wdata,
	input  logic             pop,
	output logic             empty,
	output logic [WIDTH-1:0] rdata
);

	localparam int DEPTH = 2;
	localparam int PW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
	localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PW-1:0]    wr_ptr_q;
	logic [PW-1:0]    rd_ptr_q;
	logic [CW-1:0]    count_q;
	logic             do_push;
	logic             do_pop;

	assign full    = (count_q == DEPTH_C);
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = mem_q[rd_ptr_q];

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// Entry storage.
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

`ifndef ASSERT_OFF
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= DEPTH_C)
		else $error("queue count beyond its depth");
	a_empty_ptrs: assert property (@(posedge clk) disable iff (!arst_n)
		empty |-> (rd_ptr_q == wr_ptr_q))
		else $error("empty queue with pointers apart");
	a_full_ptrs: assert property (@(posedge clk) disable iff (!arst_n)
		full |-> (rd_ptr_q == wr_ptr_q))
		else $error("full queue with pointers apart");
`endif

endmodule

`default_nettype wire

// ===== hdl/lpht_back.sv =====
// Probe sequencer: slot memory, clearing pass, linear probing and the result register.
// Depends on lpht_pkg; takes commands with their home slot from lpht_fifo.
`default_nettype none

module lpht_back #(
	parameter int TABLE_SIZE = 16,
	localparam int AW = $clog2(TABLE_SIZE)
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              entry_valid,
	output logic              entry_pop,
	input  lpht_pkg::cmd_in_t entry_item,
	input  logic [AW-1:0]     entry_home,
	output logic              clearing,
	output logic              empty,
	input  logic              pop,
	output lpht_pkg::result_t result
);
	import lpht_pkg::*;

	localparam logic [AW-1:0] LAST_SLOT = AW'(TABLE_SIZE - 1);

	localparam logic [1:0] S_CLEAR = 2'd0;
	localparam logic [1:0] S_IDLE  = 2'd1;
	localparam logic [1:0] S_PROBE = 2'd2;
	localparam logic [1:0] S_DONE  = 2'd3;

	logic [1:0]    state_q;
	logic [AW-1:0] clr_q;
	logic [AW-1:0] cnt_q;
	logic [AW-1:0] pos_q;
	logic [AW-1:0] iss_q;
	cmd_in_t       cmd_q;
	result_t       res_q;
	result_t       out_q;
	logic          out_valid_q;

	slot_t         slot_mem_q [TABLE_SIZE];
	slot_t         rdata_q;
	logic          mem_we;
	logic [AW-1:0] mem_waddr;
	slot_t         mem_wdata;
	logic [AW-1:0] mem_raddr;

	logic          out_free;
	logic          start;
	logic          stop;
	logic          last;
	logic          occupied;
	logic          match;
	result_t       res;

	function automatic logic [AW-1:0] next_slot(input logic [AW-1:0] p);
		return (p == LAST_SLOT) ? '0 : p + 1'b1;
	endfunction

	assign out_free  = !out_valid_q || pop;
	assign start     = entry_valid && ((state_q == S_IDLE) || (state_q == S_DONE && out_free));
	assign entry_pop = start;
	assign clearing  = (state_q == S_CLEAR);
	assign empty     = !out_valid_q;
	assign result    = out_q;

	// The read address runs one slot ahead of the slot being examined.
	assign mem_raddr = start ? entry_home : iss_q;
	assign last      = (cnt_q == LAST_SLOT);
	assign occupied  = (rdata_q.state == SLOT_OCCUPIED);
	assign match     = occupied && (rdata_q.key == cmd_q.key);

	// Slot evaluation and memory writes.
	always_comb begin
		stop      = 1'b0;
		res       = '0;
		res.status = ST_NOT_FOUND;
		mem_we    = 1'b0;
		mem_waddr = pos_q;
		mem_wdata = rdata_q;
		unique case (state_q)
			S_CLEAR: begin
				mem_we          = 1'b1;
				mem_waddr       = clr_q;
				mem_wdata       = '0;
				mem_wdata.state = SLOT_EMPTY;
			end
			S_PROBE: begin
				unique case (cmd_q.command)
					CMD_INSERT: begin
						if (!occupied) begin
							stop            = 1'b1;
							res.status      = ST_OK;
							mem_we          = 1'b1;
							mem_wdata.state = SLOT_OCCUPIED;
							mem_wdata.key   = cmd_q.key;
							mem_wdata.data  = cmd_q.item_value;
						end else if (last) begin
							stop       = 1'b1;
							res.status = ST_FULL;
						end
					end
					CMD_LOOKUP: begin
						if (rdata_q.state == SLOT_EMPTY) begin
							stop = 1'b1;
						end else if (match) begin
							stop            = 1'b1;
							res.status      = ST_OK;
							res.found_value = rdata_q.data;
						end else if (last) begin
							stop = 1'b1;
						end
					end
					CMD_REMOVE: begin
						if (match) begin
							stop            = 1'b1;
							res.status      = ST_OK;
							mem_we          = 1'b1;
							mem_wdata.state = SLOT_DELETED;
						end else if (last) begin
							stop = 1'b1;
						end
					end
					default: begin
						// The unused command code ends at once with no change.
						stop = 1'b1;
					end
				endcase
			end
			S_IDLE: begin
			end
			S_DONE: begin
			end
		endcase
	end

	// Slot memory with a registered read port.
	always_ff @(posedge clk) begin
		if (mem_we) begin
			slot_mem_q[mem_waddr] <= mem_wdata;
		end
		rdata_q <= slot_mem_q[mem_raddr];
	end

	// Sequencer control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			clr_q       <= '0;
			cnt_q       <= '0;
			pos_q       <= '0;
			iss_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				S_CLEAR: begin
					clr_q <= next_slot(clr_q);
					if (clr_q == LAST_SLOT) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (start) begin
						state_q <= S_PROBE;
					end
				end
				S_PROBE: begin
					if (stop) begin
						state_q <= S_DONE;
					end else begin
						cnt_q <= cnt_q + 1'b1;
						pos_q <= iss_q;
						iss_q <= next_slot(iss_q);
					end
				end
				S_DONE: begin
					if (out_free) begin
						state_q <= start ? S_PROBE : S_IDLE;
					end
				end
			endcase
			if (start) begin
				cnt_q <= '0;
				pos_q <= entry_home;
				iss_q <= next_slot(entry_home);
			end
			if (state_q == S_DONE && out_free) begin
				out_valid_q <= 1'b1;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Command, pending result and output payload.
	always_ff @(posedge clk) begin
		if (start) begin
			cmd_q <= entry_item;
		end
		if (state_q == S_PROBE && stop) begin
			res_q <= res;
		end
		if (state_q == S_DONE && out_free) begin
			out_q <= res_q;
		end
	end

`ifndef ASSERT_OFF
	a_no_start_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_CLEAR) |-> !entry_pop)
		else $error("command taken during the clearing pass");
	a_write_states: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> (state_q == S_CLEAR || state_q == S_PROBE))
		else $error("slot memory written outside clearing or probing");
	a_stop_to_done: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_PROBE && stop) |=> (state_q == S_DONE))
		else $error("finished probe did not move to result hand-off");
	a_result_loaded: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DONE && out_free) |=> out_valid_q)
		else $error("pending result was not loaded into the output register");
`endif

endmodule

`default_nettype wire
